// ----- sv/smx_pkg.sv -----
// package: opcodes, status codes, divider request and response types
`timescale 1ns / 1ps
package smx_pkg;

	localparam logic [4:0] OP_LIT = 5'd1;
	localparam logic [4:0] OP_RTN = 5'd2;
	localparam logic [4:0] OP_CAL = 5'd3;
	localparam logic [4:0] OP_POP = 5'd4;
	localparam logic [4:0] OP_PSI = 5'd5;
	localparam logic [4:0] OP_PRM = 5'd6;
	localparam logic [4:0] OP_STO = 5'd7;
	localparam logic [4:0] OP_INC = 5'd8;
	localparam logic [4:0] OP_JMP = 5'd9;
	localparam logic [4:0] OP_JPC = 5'd10;
	localparam logic [4:0] OP_CHO = 5'd11;
	localparam logic [4:0] OP_CHI = 5'd12;
	localparam logic [4:0] OP_HLT = 5'd13;
	localparam logic [4:0] OP_NDB = 5'd14;
	localparam logic [4:0] OP_NEG = 5'd15;
	localparam logic [4:0] OP_ADD = 5'd16;
	localparam logic [4:0] OP_SUB = 5'd17;
	localparam logic [4:0] OP_MUL = 5'd18;
	localparam logic [4:0] OP_DIV = 5'd19;
	localparam logic [4:0] OP_MOD = 5'd20;
	localparam logic [4:0] OP_EQL = 5'd21;
	localparam logic [4:0] OP_NEQ = 5'd22;
	localparam logic [4:0] OP_LSS = 5'd23;
	localparam logic [4:0] OP_LEQ = 5'd24;
	localparam logic [4:0] OP_GTR = 5'd25;
	localparam logic [4:0] OP_GEQ = 5'd26;
	localparam logic [4:0] OP_PSP = 5'd27;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DIVZ   = 3'd1;
	localparam logic [2:0] ST_MODZ   = 3'd2;
	localparam logic [2:0] ST_UNDER  = 3'd3;
	localparam logic [2:0] ST_BOUNDS = 3'd4;
	localparam logic [2:0] ST_PC     = 3'd5;

	localparam logic [31:0] EOF_VALUE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        start;
		logic [31:0] dvd;
		logic [31:0] dvs;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

	// stack items an opcode needs before it runs
	function automatic logic [1:0] need_items(input logic [4:0] op);
		logic [1:0] n;
		case (op)
			OP_RTN, OP_STO: n = 2'd2;
			OP_POP, OP_PSI, OP_JMP, OP_JPC, OP_CHO, OP_NEG: n = 2'd1;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQL, OP_NEQ,
			OP_LSS, OP_LEQ, OP_GTR, OP_GEQ: n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- sv/stack_machine_execute.sv -----
// top level: stack machine instruction execution unit
`timescale 1ns / 1ps
// Executes one stack machine instruction per input item on the s_ channel
// and returns exactly one result item on the m_ channel.
// After reset the stack memory is swept to zero, one word a cycle;
// s_tready stays low during that sweep.
// An item goes from acceptance through the reads of top and second item
// (with the indirect read overlapped), execute and output, plus one
// write state per stack write (0 to 2), set by the single read and
// write ports of the stack memory.
// DIV and MOD also wait for the bit-serial divider.
// A halted block still answers each item with the frozen state.
// The result sits in an output register; the next item is accepted while
// it waits, but a new result is held back until the receiver takes the old.
// s_tready is high only while no item is in progress.
module stack_machine_execute import smx_pkg::*; #(
	parameter int STACK_DEPTH = 2048,
	parameter int CODE_DEPTH  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[4:0], operand[36:5], in_char[44:37], in_eof[45], zero[47:46]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_pc[8:0], out_valid[9], out_char[17:10], halted[18], status[21:19], zero[23:22]
	output logic [23:0] m_tdata
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH + 1);
	localparam int BW = AW;
	localparam int PW = $clog2(CODE_DEPTH);
	localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);
	localparam logic signed [33:0] CODE_S  = 34'(CODE_DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_RD2, S_RD3, S_EXEC, S_DIV, S_WR, S_FIN
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_q;
	logic [SW-1:0]  sp_q;
	logic [BW-1:0]  bp_q;
	logic [PW-1:0]  pc_q;
	logic           stopped_q;
	logic [2:0]     last_st_q;
	logic [4:0]     cmd_q;
	logic signed [31:0] opnd_q;
	logic [7:0]     ch_q;
	logic           eof_q;
	logic [31:0]    top_q;
	logic [31:0]    sec_q;
	logic [AW-1:0]  wa0_q, wa1_q;
	logic [31:0]    wd0_q, wd1_q;
	logic [1:0]     nw_q;
	logic [2:0]     rst_q;
	logic           rov_q;
	logic [7:0]     roc_q;
	logic           mval_q;
	logic [21:0]    mdat_q;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [31:0]    mem_wdata;
	logic [AW-1:0]  mem_raddr;
	logic [31:0]    mem_rdata;
	div_req_t       dreq;
	div_rsp_t       drsp;

	smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	smx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic signed [33:0] sp34, bp34, pc1, ms34, top34, sec34, ind34;
	logic [SW-1:0] spm1, spm2;

	assign sp34  = signed'(34'(sp_q));
	assign bp34  = signed'(34'(bp_q));
	assign pc1   = signed'(34'(pc_q)) + 34'sd1;
	assign ms34  = 34'(opnd_q);
	assign top34 = 34'(signed'(top_q));
	assign sec34 = 34'(signed'(sec_q));
	assign spm1  = sp_q - SW'(1);
	assign spm2  = sp_q - SW'(2);
	assign ind34 = (cmd_q == OP_PSI) ? top34 : (bp34 - ms34);

	always_comb begin
		case (state_q)
			S_RD2:   mem_raddr = spm2[AW-1:0];
			S_RD3:   mem_raddr = ind34[AW-1:0];
			default: mem_raddr = spm1[AW-1:0];
		endcase
	end

	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WR);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : wa0_q;
	assign mem_wdata = (state_q == S_CLEAR) ? 32'd0 : wd0_q;

	function automatic logic addr_ok(input logic signed [33:0] a);
		return (a >= 34'sd0) && (a < DEPTH_S);
	endfunction

	// execute: new pointers, pending writes and status
	logic signed [33:0] spn, bpn, pcn, sto34;
	logic [33:0]   w0a, w1a;
	logic [31:0]   w0d, w1d, alu_r;
	logic [1:0]    nw;
	logic [2:0]    st;
	logic          halt, ov, go_div;
	logic signed [31:0] top_s, sec_s;

	assign top_s = signed'(top_q);
	assign sec_s = signed'(sec_q);
	assign sto34 = top34 + ms34;

	always_comb begin
		case (cmd_q)
			OP_ADD:  alu_r = top_q + sec_q;
			OP_SUB:  alu_r = top_q - sec_q;
			OP_MUL:  alu_r = top_q * sec_q;
			OP_EQL:  alu_r = 32'(top_s == sec_s);
			OP_NEQ:  alu_r = 32'(top_s != sec_s);
			OP_LSS:  alu_r = 32'(top_s < sec_s);
			OP_LEQ:  alu_r = 32'(top_s <= sec_s);
			OP_GTR:  alu_r = 32'(top_s > sec_s);
			OP_GEQ:  alu_r = 32'(top_s >= sec_s);
			default: alu_r = 32'd0;
		endcase
	end

	always_comb begin
		spn = sp34;
		bpn = bp34;
		pcn = pc1;
		w0a = 34'(sp34);
		w1a = 34'(sp34 + 34'sd1);
		w0d = 32'd0;
		w1d = 32'd0;
		nw = 2'd0;
		st = ST_OK;
		halt = 1'b0;
		ov = 1'b0;
		go_div = 1'b0;
		if (sp34 < signed'(34'(need_items(cmd_q)))) begin
			st = ST_UNDER;
		end else begin
			case (cmd_q)
				OP_LIT: begin
					w0d = opnd_q; nw = 2'd1; spn = sp34 + 34'sd1;
				end
				OP_RTN: begin
					pcn = top34; bpn = sec34; spn = sp34 - 34'sd2;
				end
				OP_CAL: begin
					w0d = 32'(bp_q); w1d = pc1[31:0]; nw = 2'd2;
					bpn = sp34; spn = sp34 + 34'sd2; pcn = ms34;
				end
				OP_POP: spn = sp34 - 34'sd1;
				OP_PSI: begin
					if (!addr_ok(top34)) st = ST_BOUNDS;
					w0a = 34'(sp34 - 34'sd1); w0d = mem_rdata; nw = 2'd1;
				end
				OP_PRM: begin
					if (!addr_ok(ind34)) st = ST_BOUNDS;
					w0d = mem_rdata; nw = 2'd1; spn = sp34 + 34'sd1;
				end
				OP_STO: begin
					if (!addr_ok(sto34)) st = ST_BOUNDS;
					w0a = 34'(sto34); w0d = sec_q; nw = 2'd1; spn = sp34 - 34'sd2;
				end
				OP_INC: spn = sp34 + ms34;
				OP_JMP: begin
					pcn = top34; spn = sp34 - 34'sd1;
				end
				OP_JPC: begin
					if (top_q != 32'd0) pcn = ms34;
					spn = sp34 - 34'sd1;
				end
				OP_CHO: begin
					ov = 1'b1; spn = sp34 - 34'sd1;
				end
				OP_CHI: begin
					w0d = eof_q ? EOF_VALUE : {24'd0, ch_q}; nw = 2'd1;
					spn = sp34 + 34'sd1;
				end
				OP_HLT: halt = 1'b1;
				OP_NEG: begin
					w0a = 34'(sp34 - 34'sd1); w0d = 32'd0 - top_q; nw = 2'd1;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR,
				OP_GEQ, OP_DIV, OP_MOD: begin
					if (cmd_q == OP_DIV && sec_q == 32'd0) st = ST_DIVZ;
					if (cmd_q == OP_MOD && sec_q == 32'd0) st = ST_MODZ;
					go_div = (cmd_q == OP_DIV) || (cmd_q == OP_MOD);
					w0a = 34'(sp34 - 34'sd2); w0d = alu_r; nw = 2'd1;
					spn = sp34 - 34'sd1;
				end
				OP_PSP: begin
					w0d = 32'(sp_q); nw = 2'd1; spn = sp34 + 34'sd1;
				end
				default: ;
			endcase
			if (st == ST_OK) begin
				if (spn < 34'sd0) st = ST_UNDER;
				else if (!(bpn >= 34'sd0 && bpn <= spn && spn < DEPTH_S)) st = ST_BOUNDS;
				else if (!(pcn >= 34'sd0 && pcn < CODE_S)) st = ST_PC;
			end
		end
	end

	assign dreq.start = (state_q == S_EXEC) && go_div && (st == ST_OK);
	assign dreq.dvd   = top_q[31] ? (32'd0 - top_q) : top_q;
	assign dreq.dvs   = sec_q[31] ? (32'd0 - sec_q) : sec_q;

	logic [31:0] div_r;
	always_comb begin
		if (cmd_q == OP_DIV) begin
			div_r = (top_q[31] ^ sec_q[31]) ? (32'd0 - drsp.quo) : drsp.quo;
		end else begin
			div_r = top_q[31] ? (32'd0 - drsp.rem) : drsp.rem;
		end
	end

	logic [31:0] pc_wide;
	assign pc_wide = 32'(pc_q);

	// result register loads when empty or when the old item leaves
	logic fin_go;
	assign fin_go = (state_q == S_FIN) && (!mval_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			sp_q      <= '0;
			bp_q      <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
			last_st_q <= ST_OK;
			nw_q      <= '0;
			mval_q    <= 1'b0;
		end else begin
			if (mval_q && m_tready && !fin_go) mval_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STACK_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q  <= s_tdata[4:0];
						opnd_q <= signed'(s_tdata[36:5]);
						ch_q   <= s_tdata[44:37];
						eof_q  <= s_tdata[45];
						if (stopped_q) begin
							rst_q   <= last_st_q;
							rov_q   <= 1'b0;
							roc_q   <= 8'd0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_RD2;
						end
					end
				end
				S_RD2: begin
					top_q   <= (sp_q >= SW'(1)) ? mem_rdata : 32'd0;
					state_q <= S_RD3;
				end
				S_RD3: begin
					sec_q   <= (sp_q >= SW'(2)) ? mem_rdata : 32'd0;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					wa0_q <= w0a[AW-1:0];
					wa1_q <= w1a[AW-1:0];
					wd0_q <= w0d;
					wd1_q <= w1d;
					rst_q <= st;
					rov_q <= 1'b0;
					roc_q <= 8'd0;
					if (st != ST_OK) begin
						stopped_q <= 1'b1;
						last_st_q <= st;
						state_q   <= S_FIN;
					end else begin
						sp_q      <= spn[SW-1:0];
						bp_q      <= bpn[BW-1:0];
						pc_q      <= pcn[PW-1:0];
						last_st_q <= ST_OK;
						stopped_q <= halt;
						rov_q     <= ov;
						roc_q     <= ov ? top_q[7:0] : 8'd0;
						nw_q      <= nw;
						if (go_div) state_q <= S_DIV;
						else if (nw == 2'd0) state_q <= S_FIN;
						else state_q <= S_WR;
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						wd0_q   <= div_r;
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (nw_q == 2'd2) begin
						wa0_q <= wa1_q;
						wd0_q <= wd1_q;
						nw_q  <= 2'd1;
					end else begin
						nw_q    <= 2'd0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						mval_q  <= 1'b1;
						mdat_q  <= {rst_q, stopped_q, roc_q, rov_q, pc_wide[8:0]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mval_q;
	assign m_tdata  = {2'b00, mdat_q};

endmodule

// ----- sv/smx_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/smx_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module smx_div import smx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dvd;
			dvs_q <= req.dvs;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule
